### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/pesp_pkg.sv
package pesp_pkg;

    // Parser phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    // Result word kind
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_TIMING  = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // Packet error codes
    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_START  = 3'd1,
        ERR_STREAM = 3'd2,
        ERR_MARKER = 3'd3,
        ERR_FLAGS  = 3'd4,
        ERR_SHORT  = 3'd5
    } t_err;

    // Timestamp presence codes from the flags byte
    localparam logic [1:0] PD_NONE   = 2'b00;
    localparam logic [1:0] PD_FORBID = 2'b01;
    localparam logic [1:0] PD_BOTH   = 2'b11;

    // Start code and marker bits
    localparam logic [7:0] START_ZERO  = 8'h00;
    localparam logic [7:0] START_ONE   = 8'h01;
    localparam logic [7:0] MARKER_MASK = 8'hC0;
    localparam logic [7:0] MARKER_VAL  = 8'h80;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TIME = 2'd1;
    localparam int unsigned CFG_DATA_W = 40;

    localparam logic [7:0]  STREAM_ID_RST = 8'hE0;
    localparam logic [39:0] LEAD_TIME_RST = 40'd5000000000;

    // pts*100000/9 = pts*11111 + pts/9 ; pts/9 by reciprocal with one correction
    localparam logic [32:0] RECIP9      = 33'd7635497415; // floor(2^36 / 9)
    localparam int unsigned RECIP9_SH   = 36;
    localparam logic [13:0] MUL_11111   = 14'd11111;
    localparam int unsigned QUOT_W      = 30;
    localparam int unsigned TIME_W      = 47;

    // One result word
    typedef struct packed {
        t_kind        kind;
        logic [7:0]   data;
        logic         last;
        logic [32:0]  pts;
        logic [32:0]  dts;
        logic         dts_present;
        logic [63:0]  rel;
        t_err         err;
    } t_result;

    // A pipeline stage: word present plus its contents
    typedef struct packed {
        logic    vld;
        t_result res;
    } t_stage;

    // Sum of optional header field sizes named by the flags byte
    function automatic logic [4:0] flag_sum(input logic [7:0] f);
        logic [4:0] s;
        s = (f[7:6] == PD_BOTH) ? 5'd10 : 5'd5;
        if (f[5]) s = s + 5'd6;
        if (f[4]) s = s + 5'd3;
        if (f[3]) s = s + 5'd1;
        if (f[2]) s = s + 5'd1;
        if (f[1]) s = s + 5'd2;
        return s;
    endfunction

endpackage

### hw/rtl/pesp_parse.sv
module pesp_parse
    import pesp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [7:0] i_stream_id,
    output t_stage     o_stage,
    output logic       o_drop
);

    // Input word register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [8:0]  r_pos, n_pos;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_hlen, n_hlen;
    logic [32:0] r_pts, n_pts;
    logic [32:0] r_dts, n_dts;

    // Result register
    logic    r_s1_vld;
    t_result r_s1_res;

    // Decode results
    t_err        w_err;
    logic        w_nopts;
    logic        w_timing;
    logic [32:0] w_pts;
    logic [32:0] w_dts;
    logic        w_has;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // Header byte decode by position
    always_comb begin
        w_err   = ERR_NONE;
        w_nopts = 1'b0;
        w_pts   = r_pts;
        w_dts   = r_dts;
        unique case (r_pos) inside
            9'd0, 9'd1: if (r_in_byte != START_ZERO) w_err = ERR_START;
            9'd2:       if (r_in_byte != START_ONE) w_err = ERR_START;
            9'd3:       if (r_in_byte != i_stream_id) w_err = ERR_STREAM;
            9'd6:       if ((r_in_byte & MARKER_MASK) != MARKER_VAL) w_err = ERR_MARKER;
            9'd7: begin
                if (r_in_byte[7:6] == PD_NONE) w_nopts = 1'b1;
                else if (r_in_byte[7:6] == PD_FORBID) w_err = ERR_FLAGS;
            end
            9'd8:  if ({3'b0, flag_sum(r_flags)} > r_in_byte) w_err = ERR_SHORT;
            9'd9:  w_pts = {r_in_byte[3:1], 30'b0};
            9'd10: w_pts = r_pts | {3'b0, r_in_byte, 22'b0};
            9'd11: w_pts = r_pts | {11'b0, r_in_byte[7:1], 15'b0};
            9'd12: w_pts = r_pts | {18'b0, r_in_byte, 7'b0};
            9'd13: w_pts = r_pts | {26'b0, r_in_byte[7:1]};
            9'd14: w_dts = {r_in_byte[3:1], 30'b0};
            9'd15: w_dts = r_dts | {3'b0, r_in_byte, 22'b0};
            9'd16: w_dts = r_dts | {11'b0, r_in_byte[7:1], 15'b0};
            9'd17: w_dts = r_dts | {18'b0, r_in_byte, 7'b0};
            9'd18: w_dts = r_dts | {26'b0, r_in_byte[7:1]};
            default: ;
        endcase
        // last header byte reached: timing word goes out
        w_timing = (r_pos >= 9'd9) && (r_pos == 9'd8 + {1'b0, r_hlen});
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_flags = r_flags;
        n_hlen  = r_hlen;
        n_pts   = r_pts;
        n_dts   = r_dts;
        if (r_in_vld) begin
            unique case (r_phase)
                PH_PAYLOAD, PH_DROP: begin
                    if (r_in_last) begin
                        n_phase = PH_HEADER;
                        n_pos   = '0;
                    end
                end
                PH_HEADER: begin
                    if (r_pos == 9'd7) n_flags = r_in_byte;
                    if (r_pos == 9'd8) n_hlen = r_in_byte;
                    n_pts = w_pts;
                    n_dts = w_dts;
                    if (r_in_last) begin
                        n_phase = PH_HEADER;
                        n_pos   = '0;
                    end else if (w_err != ERR_NONE || w_nopts) begin
                        n_phase = PH_DROP;
                    end else if (w_timing) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_pos = r_pos + 9'd1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    n_pos   = '0;
                end
            endcase
        end
    end

    // Result word
    always_comb begin
        w_has = 1'b0;
        w_res = '0;
        if (r_in_vld) begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    w_has      = 1'b1;
                    w_res.kind = KIND_PAYLOAD;
                    w_res.data = r_in_byte;
                    w_res.last = r_in_last;
                end
                PH_HEADER: begin
                    if (w_err != ERR_NONE) begin
                        w_has      = 1'b1;
                        w_res.kind = KIND_ERROR;
                        w_res.last = 1'b1;
                        w_res.err  = w_err;
                    end else if (w_nopts) begin
                        w_has = 1'b0;
                    end else if (w_timing) begin
                        w_has             = 1'b1;
                        w_res.kind        = KIND_TIMING;
                        w_res.last        = r_in_last;
                        w_res.pts         = w_pts;
                        w_res.dts_present = (r_flags[7:6] == PD_BOTH);
                        w_res.dts         = (r_flags[7:6] == PD_BOTH) ? w_dts : '0;
                    end else if (r_in_last) begin
                        // packet ended inside the header
                        w_has      = 1'b1;
                        w_res.kind = KIND_ERROR;
                        w_res.last = 1'b1;
                        w_res.err  = ERR_SHORT;
                    end
                end
                default: w_has = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_flags  <= '0;
            r_hlen   <= '0;
            r_pts    <= '0;
            r_dts    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_hlen   <= n_hlen;
            r_pts    <= n_pts;
            r_dts    <= n_dts;
            r_s1_vld <= w_has;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_res <= w_res;
    end

    always_comb begin
        o_stage.vld = r_s1_vld;
        o_stage.res = r_s1_res;
    end

    // word consumed without a result frees its slot
    assign o_drop = r_in_vld && !w_has;

endmodule

### hw/rtl/pesp_time.sv
module pesp_time
    import pesp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stage      i_stage,
    input  logic [39:0] i_lead_time,
    output t_stage      o_stage
);

    logic                r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    t_result             r_s2_res, r_s3_res, r_s4_res, r_s5_res, r_s6_res;
    logic [QUOT_W-1:0]   r_s2_q0, r_s3_q0;
    logic [TIME_W-1:0]   r_s3_c;
    logic [4:0]          r_s3_rem;
    logic [TIME_W-1:0]   r_s4_t, r_s5_t;
    logic [63:0]         r_s5_cand;
    logic [63:0]         r_base;
    logic                r_base_valid;

    logic [65:0]         w_prod;
    logic [TIME_W-1:0]   w_c;
    logic [32:0]         w_nine_q;
    logic [32:0]         w_rem;
    logic [TIME_W-1:0]   w_t;
    logic [63:0]         w_cand;
    logic [63:0]         w_base_sel;
    logic                w_s5_timing;
    t_result             w_s6_res;

    // Stage 2: quotient estimate of pts/9
    assign w_prod = 66'(i_stage.res.pts) * 66'(RECIP9);

    // Stage 3: pts*11111 and remainder of the estimate
    assign w_c      = TIME_W'(r_s2_res.pts) * TIME_W'(MUL_11111);
    assign w_nine_q = {r_s2_q0, 3'b000} + {3'b000, r_s2_q0};
    assign w_rem    = r_s2_res.pts - w_nine_q;

    // Stage 4: corrected quotient, time in ns
    assign w_t = r_s3_c + TIME_W'(r_s3_q0) + TIME_W'(r_s3_rem >= 5'd9);

    // Stage 5: candidate base
    assign w_cand = 64'(r_s4_t) - 64'(i_lead_time);

    // Stage 6: latch base on first timing word, relative time
    assign w_s5_timing = r_s5_vld && (r_s5_res.kind == KIND_TIMING);
    assign w_base_sel  = r_base_valid ? r_base : r_s5_cand;

    always_comb begin
        w_s6_res = r_s5_res;
        if (r_s5_res.kind == KIND_TIMING) begin
            w_s6_res.rel = 64'(r_s5_t) - w_base_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_s4_vld     <= 1'b0;
            r_s5_vld     <= 1'b0;
            r_s6_vld     <= 1'b0;
            r_base_valid <= 1'b0;
        end else begin
            r_s2_vld <= i_stage.vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            if (w_s5_timing) r_base_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_res  <= i_stage.res;
        r_s2_q0   <= w_prod[RECIP9_SH +: QUOT_W];
        r_s3_res  <= r_s2_res;
        r_s3_q0   <= r_s2_q0;
        r_s3_c    <= w_c;
        r_s3_rem  <= w_rem[4:0];
        r_s4_res  <= r_s3_res;
        r_s4_t    <= w_t;
        r_s5_res  <= r_s4_res;
        r_s5_t    <= r_s4_t;
        r_s5_cand <= w_cand;
        r_s6_res  <= w_s6_res;
        if (w_s5_timing && !r_base_valid) r_base <= r_s5_cand;
    end

    always_comb begin
        o_stage.vld = r_s6_vld;
        o_stage.res = r_s6_res;
    end

endmodule

### hw/rtl/pesp_fifo.sv
module pesp_fifo
    import pesp_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_result                    i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_result                    o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) n_count = r_count + CW'(1);
        if (!i_push && w_pop) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            if (w_pop)  r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            r_count <= n_count;
        end
    end

    // Word storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

### hw/rtl/pes_header_parser_timestamp.sv
// PES header parser with PTS/DTS extraction and PTS to nanosecond conversion.
// Results pass the input and parse registers, the time stages and the queue.
// Throughput: one byte per cycle; the output queue (P_FIFO_DEPTH words) is
// reserved per accepted byte, so full rate needs P_FIFO_DEPTH >= 9.
// Reset (synchronous, active low): header phase, no timestamp base latched,
// queue empty, stream id 0xE0, lead time 5 s.
`include "assert_macros.svh"

module pes_header_parser_timestamp
    import pesp_pkg::*;
#(
    parameter int unsigned P_FIFO_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_out_kind,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last,
    output logic [32:0]           o_pts_value,
    output logic [32:0]           o_dts_value,
    output logic                  o_dts_present,
    output logic [63:0]           o_rel_time_ns,
    output logic [2:0]            o_error_code,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned CW = $clog2(P_FIFO_DEPTH+1);

    logic [7:0]   r_stream_id;
    logic [39:0]  r_lead_time;
    logic [CW-1:0] r_used, n_used;

    logic         w_accept;
    logic         w_pop;
    logic         w_drop;
    t_stage       w_parse_stage;
    t_stage       w_time_stage;
    t_result      w_head;
    logic [CW-1:0] w_fifo_count;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pop      = o_out_valid && i_out_ready;
    assign o_in_ready = (r_used < CW'(P_FIFO_DEPTH));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_id <= STREAM_ID_RST;
            r_lead_time <= LEAD_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STREAM_ID: r_stream_id <= i_cfg_data[7:0];
                CFG_LEAD_TIME: r_lead_time <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Queue slots held by words in flight or waiting
    always_comb begin
        n_used = r_used + CW'(w_accept) - CW'(w_drop) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    pesp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_byte      (i_in_byte),
        .i_last      (i_in_last),
        .i_stream_id (r_stream_id),
        .o_stage     (w_parse_stage),
        .o_drop      (w_drop)
    );

    pesp_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_parse_stage),
        .i_lead_time (r_lead_time),
        .o_stage     (w_time_stage)
    );

    pesp_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_time_stage.vld),
        .i_data  (w_time_stage.res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    // Output word fields
    assign o_out_kind    = w_head.kind;
    assign o_out_byte    = w_head.data;
    assign o_out_last    = w_head.last;
    assign o_pts_value   = w_head.pts;
    assign o_dts_value   = w_head.dts;
    assign o_dts_present = w_head.dts_present;
    assign o_rel_time_ns = w_head.rel;
    assign o_error_code  = w_head.err;

    // Checks
    `ASSERT_ALWAYS(a_slot_bound, i_clk, i_rst_n, (w_fifo_count <= r_used) && (r_used <= CW'(P_FIFO_DEPTH)))
    `ASSERT_IMPLIES(a_err_word, i_clk, i_rst_n, o_out_valid && (o_out_kind == KIND_ERROR), o_out_last && (o_error_code != ERR_NONE))
    `ASSERT_IMPLIES(a_payload_word, i_clk, i_rst_n, o_out_valid && (o_out_kind == KIND_PAYLOAD), (o_error_code == ERR_NONE) && (o_rel_time_ns == '0) && !o_dts_present)
    `ASSERT_NEXT(a_slot_free, i_clk, i_rst_n, w_pop && !w_accept && !w_drop, r_used == $past(r_used) - CW'(1))

endmodule

### tb/pes_header_parser_timestamp_tb.sv
module pes_header_parser_timestamp_tb
    import pesp_pkg::*;
();

    localparam int IDLE_PCT     = 28;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_BYTES  = 500;
    localparam int NUM_PHASES   = 4;
    localparam int DIR_N        = 27;

    // PTS only, no DTS
    localparam logic [1:0] PD_PTS_ONLY = 2'b10;
    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_in_byte;
    logic                  i_in_last;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_out_kind;
    logic [7:0]            o_out_byte;
    logic                  o_out_last;
    logic [32:0]           o_pts_value;
    logic [32:0]           o_dts_value;
    logic                  o_dts_present;
    logic [63:0]           o_rel_time_ns;
    logic [2:0]            o_error_code;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pes_header_parser_timestamp DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_pts_value   (o_pts_value),
        .o_dts_value   (o_dts_value),
        .o_dts_present (o_dts_present),
        .o_rel_time_ns (o_rel_time_ns),
        .o_error_code  (o_error_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Directed packets; rows with typed set carry their expected word
    typedef struct {
        logic [7:0]  b;
        logic        l;
        logic        typed;
        t_kind       kind;
        t_err        err;
        logic [32:0] pts;
        logic [63:0] rel;
    } t_dir_row;

    t_dir_row dir_tab [DIR_N] = '{
        // bad first start code byte, packet ends there
        '{8'hFF, 1'b1, 1'b1, KIND_ERROR,   ERR_START,  33'd0, 64'd0},
        // stream id 0x00 while 0xE0 is configured
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h00, 1'b1, 1'b1, KIND_ERROR,   ERR_STREAM, 33'd0, 64'd0},
        // marker bits '11'
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hE0, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h12, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h34, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hC0, 1'b1, 1'b1, KIND_ERROR,   ERR_MARKER, 33'd0, 64'd0},
        // one byte packet: header cut short
        '{8'h00, 1'b1, 1'b1, KIND_ERROR,   ERR_SHORT,  33'd0, 64'd0},
        // all-ones PTS, header ends on the last byte; first time gives rel = lead
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h01, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hE0, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h00, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h80, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'h05, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_PAYLOAD, ERR_NONE,   33'd0, 64'd0},
        '{8'hFF, 1'b1, 1'b1, KIND_TIMING,  ERR_NONE,
          33'h1_FFFF_FFFF, 64'd5000000000}
    };

    // Parser model state and its copy of the registers
    t_phase      ph;
    logic [8:0]  pos;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_len;
    logic [32:0] pts_acc;
    logic [32:0] dts_acc;
    logic [63:0] base;
    logic        base_ok;
    logic [7:0]  cfg_sid;
    logic [39:0] cfg_lead;

    t_result     pending_words [$];
    logic [7:0]  pkt_bytes [$];
    int          parsed_bytes = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;
    logic        steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bytes of optional header fields that the flags byte announces
    function automatic int opt_field_bytes(input logic [7:0] f);
        int n;
        n = (f[7:6] == PD_BOTH) ? 10 : 5;   // PTS, or PTS and DTS
        if (f[5]) n += 6;                   // ESCR
        if (f[4]) n += 3;                   // ES rate
        if (f[3]) n += 1;                   // trick mode
        if (f[2]) n += 1;                   // copy info
        if (f[1]) n += 2;                   // CRC
        return n;
    endfunction

    // Advance the parser model by one input byte
    task parse_byte(input logic [7:0] b, input logic l, output logic got,
                    output t_result w);
        logic [1:0]  pd;
        t_err        err;
        logic        skip;
        logic [63:0] ns;
        pd   = hdr_flags[7:6];
        err  = ERR_NONE;
        skip = 1'b0;
        got  = 1'b0;
        w    = '0;
        parsed_bytes++;
        if (ph == PH_PAYLOAD) begin
            w.kind = KIND_PAYLOAD;
            w.data = b;
            w.last = l;
            got    = 1'b1;
            if (l) begin
                ph  = PH_HEADER;
                pos = '0;
            end
            return;
        end
        if (ph == PH_DROP) begin
            if (l) begin
                ph  = PH_HEADER;
                pos = '0;
            end
            return;
        end

        case (pos)
            9'd0, 9'd1: if (b != START_ZERO) err = ERR_START;
            9'd2: if (b != START_ONE) err = ERR_START;
            9'd3: if (b != cfg_sid) err = ERR_STREAM;
            9'd6: if ((b & MARKER_MASK) != MARKER_VAL) err = ERR_MARKER;
            9'd7: begin
                hdr_flags = b;
                pd = b[7:6];
                if (pd == PD_NONE) skip = 1'b1;
                else if (pd == PD_FORBID) err = ERR_FLAGS;
            end
            9'd8: begin
                hdr_len = b;
                if (opt_field_bytes(hdr_flags) > int'(b)) err = ERR_SHORT;
            end
            // 33-bit stamps, internal marker bits dropped
            9'd9:  pts_acc = {b[3:1], 30'd0};
            9'd10: pts_acc |= 33'(b) << 22;
            9'd11: pts_acc |= 33'(b & 8'hFE) << 14;
            9'd12: pts_acc |= 33'(b) << 7;
            9'd13: pts_acc |= 33'(b >> 1);
            9'd14: dts_acc = {b[3:1], 30'd0};
            9'd15: dts_acc |= 33'(b) << 22;
            9'd16: dts_acc |= 33'(b & 8'hFE) << 14;
            9'd17: dts_acc |= 33'(b) << 7;
            9'd18: dts_acc |= 33'(b >> 1);
            default: ;
        endcase

        if (err != ERR_NONE) begin
            w.kind = KIND_ERROR;
            w.last = 1'b1;
            w.err  = err;
            got    = 1'b1;
            if (l) begin
                ph  = PH_HEADER;
                pos = '0;
            end else begin
                ph = PH_DROP;
            end
        end else if (skip) begin
            if (l) begin
                ph  = PH_HEADER;
                pos = '0;
            end else begin
                ph = PH_DROP;
            end
        end else if (pos >= 9'd9 && pos == 9'd8 + {1'b0, hdr_len}) begin
            // end of header: timing word, first one latches the base
            ns = (64'(pts_acc) * 64'd100000) / 64'd9;
            if (!base_ok) begin
                base    = ns - 64'(cfg_lead);
                base_ok = 1'b1;
            end
            w.kind        = KIND_TIMING;
            w.last        = l;
            w.pts         = pts_acc;
            w.dts_present = (pd == PD_BOTH);
            w.dts         = w.dts_present ? dts_acc : 33'd0;
            w.rel         = ns - base;
            got           = 1'b1;
            if (l) begin
                ph  = PH_HEADER;
                pos = '0;
            end else begin
                ph = PH_PAYLOAD;
            end
        end else if (l) begin
            w.kind = KIND_ERROR;
            w.last = 1'b1;
            w.err  = ERR_SHORT;
            got    = 1'b1;
            ph     = PH_HEADER;
            pos    = '0;
        end else begin
            pos = pos + 9'd1;
        end
    endtask

    // Offer one word on the input side and predict once it is taken
    task send_word(input logic [7:0] b, input logic l, output logic got,
                   output t_result w);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_byte(b, l, got, w);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_STREAM_ID) cfg_sid = data[7:0];
        else if (idx == CFG_LEAD_TIME) cfg_lead = data;
    endtask

    // Stop sending, let every expected word drain, then let the pipe settle
    task wait_idle;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // One random packet: mostly well formed, the rest broken or noise
    task build_packet;
        int          mode;
        int          hlen_min;
        int          cut;
        logic [7:0]  fl;
        logic [7:0]  hl;
        logic [1:0]  mk;
        pkt_bytes.delete();
        mode = $urandom_range(0, 99);
        if (mode >= 95) begin
            repeat ($urandom_range(1, 20)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        fl = {($urandom_range(0, 1) ? PD_BOTH : PD_PTS_ONLY),
              (($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd0)};
        hlen_min = opt_field_bytes(fl);
        // an occasional long stuffed header
        if ($urandom_range(0, 49) == 0) hl = 8'($urandom_range(hlen_min, 255));
        else hl = 8'(hlen_min + $urandom_range(0, 3));
        pkt_bytes = '{START_ZERO, START_ZERO, START_ONE, cfg_sid, 8'($urandom),
                      8'($urandom), {MARKER_VAL[7:6], 6'($urandom)}, fl, hl};
        repeat (hl) pkt_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 24)) pkt_bytes.push_back(8'($urandom));

        if (mode < 65) begin
            // well formed
        end else if (mode < 69) begin
            cut = $urandom_range(0, 2);
            pkt_bytes[cut] = pkt_bytes[cut] ^ 8'($urandom_range(1, 255));
        end else if (mode < 73) begin
            pkt_bytes[3] = pkt_bytes[3] ^ 8'($urandom_range(1, 255));
        end else if (mode < 77) begin
            mk = 2'($urandom_range(0, 2));
            if (mk == 2'd2) mk = 2'd3;
            pkt_bytes[6] = {mk, pkt_bytes[6][5:0]};
        end else if (mode < 81) begin
            pkt_bytes[7] = {PD_NONE, pkt_bytes[7][5:0]};
        end else if (mode < 84) begin
            pkt_bytes[7] = {PD_FORBID, pkt_bytes[7][5:0]};
        end else if (mode < 88) begin
            pkt_bytes[8] = 8'($urandom_range(0, hlen_min - 1));
        end else begin
            // cut before the header is complete
            cut = $urandom_range(1, 8 + hl);
            while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end
    endtask

    // Output side stalls
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each taken result word with the oldest expected one
    always @(posedge i_clk) begin : check_words
        t_result w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word: kind %0d byte %0h err %0d",
                       o_out_kind, o_out_byte, o_error_code);
                mismatches++;
            end else begin
                w = pending_words.pop_front();
                if (o_out_kind !== w.kind) begin
                    $error("out_kind: expected %0d, actual %0d", w.kind, o_out_kind);
                    mismatches++;
                end
                if (o_out_byte !== w.data) begin
                    $error("out_byte: expected %0h, actual %0h", w.data, o_out_byte);
                    mismatches++;
                end
                if (o_out_last !== w.last) begin
                    $error("out_last: expected %0d, actual %0d", w.last, o_out_last);
                    mismatches++;
                end
                if (o_pts_value !== w.pts) begin
                    $error("pts_value: expected %0h, actual %0h", w.pts, o_pts_value);
                    mismatches++;
                end
                if (o_dts_value !== w.dts) begin
                    $error("dts_value: expected %0h, actual %0h", w.dts, o_dts_value);
                    mismatches++;
                end
                if (o_dts_present !== w.dts_present) begin
                    $error("dts_present: expected %0d, actual %0d",
                           w.dts_present, o_dts_present);
                    mismatches++;
                end
                if (o_rel_time_ns !== w.rel) begin
                    $error("rel_time_ns: expected %0d, actual %0d", w.rel, o_rel_time_ns);
                    mismatches++;
                end
                if (o_error_code !== w.err) begin
                    $error("error_code: expected %0d, actual %0d", w.err, o_error_code);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic    got;
        t_result w;
        int      target;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = '0;
        i_in_last   = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_STREAM_ID;
        i_cfg_data  = '0;

        ph        = PH_HEADER;
        pos       = '0;
        hdr_flags = '0;
        hdr_len   = '0;
        pts_acc   = '0;
        dts_acc   = '0;
        base      = '0;
        base_ok   = 1'b0;
        cfg_sid   = STREAM_ID_RST;
        cfg_lead  = LEAD_TIME_RST;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed packets at reset settings
        for (int i = 0; i < DIR_N; i++) begin
            send_word(dir_tab[i].b, dir_tab[i].l, got, w);
            if (dir_tab[i].typed) begin
                w      = '0;
                w.kind = dir_tab[i].kind;
                w.last = dir_tab[i].l;
                w.pts  = dir_tab[i].pts;
                w.rel  = dir_tab[i].rel;
                w.err  = dir_tab[i].err;
                pending_words.push_back(w);
            end else if (got) begin
                pending_words.push_back(w);
            end
        end

        // random packets under several register settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_idle();
                case (p)
                    1: begin
                        write_reg(CFG_STREAM_ID, CFG_DATA_W'($urandom_range(0, 255)));
                        write_reg(CFG_LEAD_TIME, '0);
                        write_reg(CFG_SPARE_2, CFG_DATA_W'({$urandom, $urandom}));
                        write_reg(CFG_SPARE_3, CFG_DATA_W'({$urandom, $urandom}));
                    end
                    2: begin
                        write_reg(CFG_STREAM_ID, CFG_DATA_W'(8'hFF));
                        write_reg(CFG_LEAD_TIME, '1);
                    end
                    default: begin
                        write_reg(CFG_STREAM_ID, CFG_DATA_W'(8'h00));
                        write_reg(CFG_LEAD_TIME, CFG_DATA_W'({$urandom, $urandom}));
                    end
                endcase
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
            end
            // one phase runs with no idling on either side
            steady = (p == 1);
            target = parsed_bytes + PHASE_BYTES;
            while (parsed_bytes < target) begin
                build_packet();
                foreach (pkt_bytes[i]) begin
                    send_word(pkt_bytes[i], i == pkt_bytes.size() - 1, got, w);
                    if (got) pending_words.push_back(w);
                end
            end
        end

        wait_idle();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
